>>> design/dcts_pkg.sv
// Shared types, codes and helper functions for the DMA channel transfer step core.
`default_nettype none

package dcts_pkg;

    // Default number of channels held in the channel memory.
    localparam int NUM_CHANNELS_DEF = 4;

    // Request kinds carried in the input tuser field.
    typedef enum logic [1:0] {
        REQ_SETUP     = 2'd0,
        REQ_TRIGGER   = 2'd1,
        REQ_READ_BYTE = 2'd2,
        REQ_UNUSED    = 2'd3
    } req_kind_t;

    // Channel register selectors for setup items.
    typedef enum logic [1:0] {
        SEL_SOURCE    = 2'd0,
        SEL_TARGET    = 2'd1,
        SEL_COUNT     = 2'd2,
        SEL_MODE_SIZE = 2'd3
    } reg_sel_t;

    // Result kinds carried in the output tuser field.
    localparam logic [1:0] OP_READ   = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_STATUS = 2'd2;

    // Transfer modes.
    localparam logic [2:0] MODE_INC_TGT = 3'd0;
    localparam logic [2:0] MODE_DEC_TGT = 3'd1;
    localparam logic [2:0] MODE_INC_SRC = 3'd2;
    localparam logic [2:0] MODE_DEC_SRC = 3'd3;
    localparam logic [2:0] MODE_HOLD    = 3'd4;
    localparam logic [2:0] MODE_SRC_ONLY = 3'd5;

    // Cycle charges reported in the status item.
    localparam logic [3:0] COST_WIDE   = 4'd12;
    localparam logic [3:0] COST_NARROW = 4'd8;
    localparam logic [3:0] COST_IDLE   = 4'd5;

    // One channel's register set, one memory entry.
    typedef struct packed {
        logic [31:0] src;
        logic [31:0] tgt;
        logic [15:0] count;
        logic [4:0]  mode_size;
    } chan_entry_t;

    // A group of results caused by one input item, handed to the emitter.
    typedef struct packed {
        logic        is_write;
        logic [2:0]  bus_count;
        logic        status;
        logic [31:0] addr;
        logic [31:0] data;
        logic [1:0]  ch;
        logic [3:0]  cost;
        logic        done;
    } batch_t;

    // Bytes moved by one transfer unit: size code 0 one, 1 two, else four.
    function automatic logic [2:0] unit_bytes(input logic [4:0] mode_size);
        logic [2:0] n;
        unique case (mode_size[1:0])
            2'd0:    n = 3'd1;
            2'd1:    n = 3'd2;
            default: n = 3'd4;
        endcase
        return n;
    endfunction

    // Cycle charge of a unit for the given mode/size word.
    function automatic logic [3:0] unit_cost(input logic [4:0] mode_size);
        logic [3:0] c;
        if (mode_size[4:2] > MODE_HOLD) begin
            c = COST_IDLE;
        end
        else if (unit_bytes(mode_size) == 3'd4) begin
            c = COST_WIDE;
        end
        else begin
            c = COST_NARROW;
        end
        return c;
    endfunction

    // Address update and count decrement that close a transfer unit.
    function automatic chan_entry_t finish_entry(input chan_entry_t e);
        chan_entry_t r;
        logic [31:0] n32;
        r   = e;
        n32 = {29'd0, unit_bytes(e.mode_size)};
        unique case (e.mode_size[4:2])
            MODE_INC_TGT:  r.tgt = e.tgt + n32;
            MODE_DEC_TGT:  r.tgt = e.tgt - n32;
            MODE_INC_SRC:  r.src = e.src + n32;
            MODE_DEC_SRC:  r.src = e.src - n32;
            MODE_SRC_ONLY: r.src = e.src + n32;
            default:       r.src = e.src;
        endcase
        r.count = e.count - 16'd1;
        return r;
    endfunction

endpackage

`default_nettype wire

>>> design/dma_channel_transfer_step_core.sv
// Top level of the four-channel DMA transfer step core.
// Results pass from the held item to the emitter's group register. Throughput: one item
// per cycle unless an item's results wait for the emitter; a trigger sends up to four bus
// items and a last read byte up to five, one per cycle while m_tready is high, set by the
// byte-wide output. Channel memory is read and written back once per item, with write
// forwarding. Reset clears all control state; entries read as zero until first written.
`default_nettype none

module dma_channel_transfer_step_core #(
    parameter int NUM_CHANNELS = dcts_pkg::NUM_CHANNELS_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [47:0] s_tdata,   // channel, reg_select, reg_value, read_byte, zero fill
    input  wire  [1:0]  s_tuser,   // req_type
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [47:0] m_tdata,   // bus_address, bus_data, status_channel, cycle_cost,
                                   // transfer_done, zero fill
    output logic [1:0]  m_tuser,   // op_kind
    output logic        m_tlast    // last_of_run
);
    import dcts_pkg::*;

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic            mem_rd_en;
    logic [CH_W-1:0] mem_rd_addr;
    chan_entry_t     mem_rd_data;
    logic            mem_wr_en;
    logic [CH_W-1:0] mem_wr_addr;
    chan_entry_t     mem_wr_data;
    logic            batch_valid;
    logic            batch_free;
    batch_t          batch;

    // Channel register memory
    dcts_chan_mem #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    // Item decode and read-modify-write
    dcts_engine #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_req      (req_kind_t'(s_tuser)),
        .in_ch       (s_tdata[1:0]),
        .in_sel      (s_tdata[3:2]),
        .in_val      (s_tdata[35:4]),
        .in_rb       (s_tdata[43:36]),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .batch_valid (batch_valid),
        .batch_free  (batch_free),
        .batch       (batch)
    );

    // Result serializer
    dcts_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .batch_valid (batch_valid),
        .batch_free  (batch_free),
        .batch       (batch),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

`default_nettype wire

>>> design/dcts_chan_mem.sv
// Channel register memory with registered read and per-entry valid bits.
`default_nettype none

module dcts_chan_mem #(
    parameter int NUM_CHANNELS = dcts_pkg::NUM_CHANNELS_DEF,
    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    rd_en,
    input  wire [CH_W-1:0]         rd_addr,
    output dcts_pkg::chan_entry_t  rd_data,
    input  wire                    wr_en,
    input  wire [CH_W-1:0]         wr_addr,
    input  dcts_pkg::chan_entry_t  wr_data
);
    import dcts_pkg::*;

    chan_entry_t             mem [NUM_CHANNELS];
    chan_entry_t             rd_data_reg;
    logic [NUM_CHANNELS-1:0] valid_reg;
    logic                    rd_valid_reg;

    // Storage array: written and read in the clock domain, read-before-write.
    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Entries never written read back as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else begin
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

>>> design/dcts_engine.sv
// Read-modify-write stage: decodes items, updates channel entries and transfer state.
`default_nettype none

module dcts_engine #(
    parameter int NUM_CHANNELS = dcts_pkg::NUM_CHANNELS_DEF,
    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
    input  wire                    clk,
    input  wire                    rst_n,
    // Incoming item
    input  wire                    in_valid,
    output logic                   in_ready,
    input  dcts_pkg::req_kind_t    in_req,
    input  wire [1:0]              in_ch,
    input  wire [1:0]              in_sel,
    input  wire [31:0]             in_val,
    input  wire [7:0]              in_rb,
    // Channel memory
    output logic                   mem_rd_en,
    output logic [CH_W-1:0]        mem_rd_addr,
    input  dcts_pkg::chan_entry_t  mem_rd_data,
    output logic                   mem_wr_en,
    output logic [CH_W-1:0]        mem_wr_addr,
    output dcts_pkg::chan_entry_t  mem_wr_data,
    // Result group to the emitter
    output logic                   batch_valid,
    input  wire                    batch_free,
    output dcts_pkg::batch_t       batch
);
    import dcts_pkg::*;

    // Item held while its channel entry is read
    logic          s1_valid_reg;
    req_kind_t     s1_req_reg;
    logic [1:0]    s1_ch_reg;
    logic [1:0]    s1_sel_reg;
    logic [31:0]   s1_val_reg;
    logic [7:0]    s1_rb_reg;
    logic [CH_W-1:0] s1_addr_reg;

    // Transfer state
    logic          awaiting_reg, awaiting_next;
    logic [1:0]    active_reg, active_next;
    logic [2:0]    pending_reg, pending_next;
    logic [31:0]   gathered_reg, gathered_next;

    // Last written entry, forwarded over the read that raced it
    logic            fwd_valid_reg;
    logic [CH_W-1:0] fwd_addr_reg;
    chan_entry_t     fwd_data_reg;

    chan_entry_t entry;
    chan_entry_t entry_new;
    chan_entry_t fin;
    logic        s1_write;
    logic        s1_has_batch;
    logic        s1_adv;
    logic        accept;
    logic        s1_ch_ok;
    logic        s1_starts_await;
    logic [2:0]  n;
    logic [2:0]  pend_eff;
    logic [2:0]  pend_dec;
    logic [2:0]  pos;
    logic [31:0] gathered_or;
    logic [1:0]  rd_ch;

    // Entry seen by the held item, newest write wins
    assign entry = (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg)) ? fwd_data_reg
                                                                    : mem_rd_data;

    assign s1_ch_ok        = ({30'd0, s1_ch_reg} < NUM_CHANNELS);
    assign s1_starts_await = s1_valid_reg && (s1_req_reg == REQ_TRIGGER) && s1_ch_ok
                             && !awaiting_reg;

    assign n           = unit_bytes(entry.mode_size);
    assign pend_eff    = ((pending_reg > n) || (pending_reg == 3'd0)) ? n : pending_reg;
    assign pend_dec    = pend_eff - 3'd1;
    assign pos         = n - pend_eff;
    assign gathered_or = gathered_reg | ({24'd0, s1_rb_reg} << {pos[1:0], 3'b000});
    assign fin         = finish_entry(entry);

    // Decode of the held item
    always_comb
    begin
        entry_new     = entry;
        s1_write      = 1'b0;
        s1_has_batch  = 1'b0;
        batch         = '0;
        awaiting_next = awaiting_reg;
        active_next   = active_reg;
        pending_next  = pending_reg;
        gathered_next = gathered_reg;
        batch.ch      = s1_ch_reg;
        if (s1_valid_reg) begin
            unique case (s1_req_reg)
                REQ_SETUP:
                begin
                    if (s1_ch_ok) begin
                        s1_write = 1'b1;
                        unique case (reg_sel_t'(s1_sel_reg))
                            SEL_SOURCE:    entry_new.src       = s1_val_reg;
                            SEL_TARGET:    entry_new.tgt       = s1_val_reg;
                            SEL_COUNT:     entry_new.count     = s1_val_reg[15:0];
                            SEL_MODE_SIZE: entry_new.mode_size = s1_val_reg[4:0];
                        endcase
                    end
                end
                REQ_TRIGGER:
                begin
                    if (s1_starts_await) begin
                        s1_has_batch = 1'b1;
                        if (entry.mode_size[4:2] > MODE_HOLD) begin
                            // No bus traffic, close the unit at once
                            s1_write        = 1'b1;
                            entry_new       = fin;
                            batch.status    = 1'b1;
                            batch.cost      = unit_cost(entry.mode_size);
                            batch.done      = (fin.count == 16'd0);
                        end
                        else begin
                            batch.bus_count = n;
                            batch.addr      = entry.src;
                            awaiting_next   = 1'b1;
                            active_next     = s1_ch_reg;
                            pending_next    = n;
                            gathered_next   = '0;
                        end
                    end
                end
                REQ_READ_BYTE:
                begin
                    if (awaiting_reg) begin
                        gathered_next = gathered_or;
                        pending_next  = pend_dec;
                        if (pend_dec == 3'd0) begin
                            // Last byte: write out the unit and report status
                            awaiting_next   = 1'b0;
                            gathered_next   = '0;
                            s1_write        = 1'b1;
                            entry_new       = fin;
                            s1_has_batch    = 1'b1;
                            batch.is_write  = 1'b1;
                            batch.bus_count = n;
                            batch.status    = 1'b1;
                            batch.addr      = entry.tgt;
                            batch.data      = gathered_or;
                            batch.ch        = active_reg;
                            batch.cost      = unit_cost(entry.mode_size);
                            batch.done      = (fin.count == 16'd0);
                        end
                    end
                end
                REQ_UNUSED:
                begin
                    s1_write = 1'b0;
                end
            endcase
        end
    end

    // Handshake between input, held item and emitter
    assign s1_adv      = s1_valid_reg && (!s1_has_batch || batch_free);
    assign in_ready    = !s1_valid_reg || s1_adv;
    assign accept      = in_valid && in_ready;
    assign batch_valid = s1_valid_reg && s1_has_batch;

    // Read port: a read byte goes to the channel whose unit is gathering
    assign rd_ch       = (in_req == REQ_READ_BYTE)
                         ? (s1_starts_await ? s1_ch_reg : active_reg) : in_ch;
    assign mem_rd_en   = accept;
    assign mem_rd_addr = CH_W'(rd_ch);
    assign mem_wr_en   = s1_adv && s1_write;
    assign mem_wr_addr = s1_addr_reg;
    assign mem_wr_data = entry_new;

    // Held item payload
    always_ff @(posedge clk)
    begin
        if (accept) begin
            s1_req_reg  <= in_req;
            s1_ch_reg   <= in_ch;
            s1_sel_reg  <= in_sel;
            s1_val_reg  <= in_val;
            s1_rb_reg   <= in_rb;
            s1_addr_reg <= CH_W'(rd_ch);
        end
        if (s1_adv) begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_data_reg <= entry_new;
        end
    end

    // Control and transfer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            awaiting_reg  <= 1'b0;
            active_reg    <= '0;
            pending_reg   <= '0;
            gathered_reg  <= '0;
            fwd_valid_reg <= 1'b0;
        end
        else begin
            if (in_ready) begin
                s1_valid_reg <= in_valid;
            end
            if (s1_adv) begin
                awaiting_reg  <= awaiting_next;
                active_reg    <= active_next;
                pending_reg   <= pending_next;
                gathered_reg  <= gathered_next;
                fwd_valid_reg <= s1_write;
            end
        end
    end

endmodule

`default_nettype wire

>>> design/dcts_emit.sv
// Output stage: sends one result group as a run of items, one per cycle while m_tready is high.
`default_nettype none

module dcts_emit (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               batch_valid,
    output logic              batch_free,
    input  dcts_pkg::batch_t  batch,
    output logic              m_tvalid,
    input  wire               m_tready,
    output logic [47:0]       m_tdata,
    output logic [1:0]        m_tuser,
    output logic              m_tlast
);
    import dcts_pkg::*;

    logic        b_valid_reg;
    batch_t      b_reg;
    batch_t      b_next;
    logic        bus_phase;
    logic        last;
    logic        take;
    logic [1:0]  kind;
    logic [31:0] addr;
    logic [7:0]  data;
    logic [1:0]  ch;
    logic [3:0]  cost;
    logic        done;

    assign bus_phase  = (b_reg.bus_count != 3'd0);
    assign last       = bus_phase ? ((b_reg.bus_count == 3'd1) && !b_reg.status) : 1'b1;
    assign take       = b_valid_reg && m_tready;
    assign batch_free = !b_valid_reg || (take && last);

    // Result fields for the current position in the group
    always_comb
    begin
        ch = b_reg.ch;
        if (bus_phase) begin
            kind = b_reg.is_write ? OP_WRITE : OP_READ;
            addr = b_reg.addr;
            data = b_reg.is_write ? b_reg.data[7:0] : 8'd0;
            cost = 4'd0;
            done = 1'b0;
        end
        else begin
            kind = OP_STATUS;
            addr = '0;
            data = '0;
            cost = b_reg.cost;
            done = b_reg.done;
        end
    end

    assign m_tvalid = b_valid_reg;
    assign m_tuser  = kind;
    assign m_tlast  = last;
    assign m_tdata  = {1'b0, done, cost, ch, data, addr};

    // Step through the group
    always_comb
    begin
        b_next = b_reg;
        if (bus_phase) begin
            b_next.bus_count = b_reg.bus_count - 3'd1;
            b_next.addr      = b_reg.addr + 32'd1;
            b_next.data      = {8'd0, b_reg.data[31:8]};
        end
        else begin
            b_next.status = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (batch_free && batch_valid) begin
            b_reg <= batch;
        end
        else if (take) begin
            b_reg <= b_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            b_valid_reg <= 1'b0;
        end
        else if (batch_free) begin
            b_valid_reg <= batch_valid;
        end
    end

endmodule

`default_nettype wire

>>> test/dma_channel_transfer_step_core_tb.sv
// Self-checking testbench for the four-channel DMA transfer step core.
`default_nettype none

module dma_channel_transfer_step_core_tb;

    import dcts_pkg::*;

    localparam int NUM_CH = NUM_CHANNELS_DEF;

    // Modes with no package name; both only charge the idle cost.
    localparam logic [2:0] MODE_NOP_LO = 3'd6;
    localparam logic [2:0] MODE_NOP_HI = 3'd7;

    // Unit size codes.
    localparam logic [1:0] SIZE_BYTE     = 2'd0;
    localparam logic [1:0] SIZE_HALF     = 2'd1;
    localparam logic [1:0] SIZE_WORD     = 2'd2;
    localparam logic [1:0] SIZE_WORD_ALT = 2'd3;

    // Receiver hold-off used to back the block up.
    localparam int HOLD_CYCLES = 300;

    // One bus item as it leaves the block.
    typedef struct {
        logic [1:0]  kind;
        logic [31:0] addr;
        logic [7:0]  data;
        logic [1:0]  ch;
        logic [3:0]  cost;
        logic        done;
        logic        last;
    } bus_op_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;    // channel, reg_select, reg_value, read_byte, zero fill
    logic [1:0]  s_tuser;    // req_type
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;    // bus_address, bus_data, status_channel, cycle_cost,
                             // transfer_done, zero fill
    logic [1:0]  m_tuser;    // op_kind
    logic        m_tlast;    // last_of_run

    // Predicted channel registers and read-gathering state.
    logic [31:0] src_addr [NUM_CH];
    logic [31:0] tgt_addr [NUM_CH];
    logic [15:0] xfer_count [NUM_CH];
    logic [4:0]  chan_mode [NUM_CH];
    logic [31:0] gather_word;
    logic [2:0]  bytes_left;
    logic [1:0]  read_channel;
    logic        reads_awaited;

    bus_op_t expected_bus_ops [$];
    int      mismatch_count;
    int      items_sent;
    bit      idling_on;
    bit      hold_req;

    dma_channel_transfer_step_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Free-running clock, period 10.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Bytes moved per unit for a mode/size word.
    function automatic logic [31:0] unit_size(input logic [4:0] ms);
        logic [31:0] n;
        case (ms[1:0])
            SIZE_BYTE: n = 32'd1;
            SIZE_HALF: n = 32'd2;
            default:   n = 32'd4;
        endcase
        return n;
    endfunction

    function automatic logic [31:0] mode_word(input logic [2:0] mode, input logic [1:0] size);
        return {27'd0, mode, size};
    endfunction

    function automatic void push_bus_op(input logic [1:0] kind, input logic [31:0] addr,
                                        input logic [7:0] data, input logic [1:0] ch,
                                        input logic [3:0] cost, input logic done,
                                        input logic last);
        bus_op_t op;
        op.kind = kind;
        op.addr = addr;
        op.data = data;
        op.ch   = ch;
        op.cost = cost;
        op.done = done;
        op.last = last;
        expected_bus_ops.push_back(op);
    endfunction

    // Close a transfer unit: move the address, count down and report status.
    function automatic void close_unit(input logic [1:0] ch);
        logic [4:0]  ms;
        logic [31:0] n;
        logic [3:0]  cost;
        ms = chan_mode[ch];
        n  = unit_size(ms);
        case (ms[4:2])
            MODE_INC_TGT:  tgt_addr[ch] = tgt_addr[ch] + n;
            MODE_DEC_TGT:  tgt_addr[ch] = tgt_addr[ch] - n;
            MODE_INC_SRC:  src_addr[ch] = src_addr[ch] + n;
            MODE_DEC_SRC:  src_addr[ch] = src_addr[ch] - n;
            MODE_SRC_ONLY: src_addr[ch] = src_addr[ch] + n;
            default:       ;
        endcase
        if (ms[4:2] <= MODE_HOLD)
            cost = (n == 32'd4) ? COST_WIDE : COST_NARROW;
        else
            cost = COST_IDLE;
        xfer_count[ch] = xfer_count[ch] - 16'd1;
        push_bus_op(OP_STATUS, 32'd0, 8'd0, ch, cost, xfer_count[ch] == 16'd0, 1'b1);
    endfunction

    // Predict the bus items caused by one accepted item; returns 1 if the item did anything.
    function automatic bit predict_dma_step(input req_kind_t req, input logic [1:0] ch,
                                            input reg_sel_t sel, input logic [31:0] val,
                                            input logic [7:0] rb);
        logic [31:0] n;
        logic [31:0] pos;
        bit          acted;
        acted = 1'b0;
        case (req)
            REQ_SETUP:
            begin
                if (ch < NUM_CH)
                begin
                    acted = 1'b1;
                    case (sel)
                        SEL_SOURCE: src_addr[ch]   = val;
                        SEL_TARGET: tgt_addr[ch]   = val;
                        SEL_COUNT:  xfer_count[ch] = val[15:0];
                        default:    chan_mode[ch]  = val[4:0];
                    endcase
                end
            end
            REQ_TRIGGER:
            begin
                if (ch < NUM_CH && !reads_awaited)
                begin
                    acted = 1'b1;
                    if (chan_mode[ch][4:2] > MODE_HOLD)
                        close_unit(ch);
                    else
                    begin
                        n = unit_size(chan_mode[ch]);
                        for (int i = 0; i < n; i++)
                            push_bus_op(OP_READ, src_addr[ch] + i, 8'd0, ch, 4'd0, 1'b0,
                                        i + 1 == n);
                        read_channel  = ch;
                        reads_awaited = 1'b1;
                        bytes_left    = n[2:0];
                        gather_word   = 32'd0;
                    end
                end
            end
            REQ_READ_BYTE:
            begin
                if (reads_awaited && read_channel < NUM_CH)
                begin
                    acted = 1'b1;
                    // The unit size may have changed under a pending read.
                    n = unit_size(chan_mode[read_channel]);
                    if (bytes_left > n || bytes_left == 3'd0)
                        bytes_left = n[2:0];
                    pos = n - bytes_left;
                    gather_word = gather_word | ({24'd0, rb} << (8 * pos[1:0]));
                    bytes_left  = bytes_left - 3'd1;
                    if (bytes_left == 3'd0)
                    begin
                        reads_awaited = 1'b0;
                        for (int i = 0; i < n; i++)
                            push_bus_op(OP_WRITE, tgt_addr[read_channel] + i,
                                        gather_word[8*i +: 8], read_channel, 4'd0, 1'b0,
                                        1'b0);
                        gather_word = 32'd0;
                        close_unit(read_channel);
                    end
                end
            end
            default: ;
        endcase
        return acted;
    endfunction

    // Offer one item, wait for the handshake and record its predicted results.
    task automatic send_item(input req_kind_t req, input logic [1:0] ch, input reg_sel_t sel,
                             input logic [31:0] val, input logic [7:0] rb);
        @(negedge clk);
        s_tuser  = req;
        s_tdata  = {4'd0, rb, val, sel, ch};
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        if (predict_dma_step(req, ch, sel, val, rb))
            items_sent++;
        // Occasional gap on the sending side.
        if (idling_on && $urandom_range(0, 4) == 0)
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
            repeat ($urandom_range(0, 16)) @(negedge clk);
        end
    endtask

    task automatic setup_reg(input logic [1:0] ch, input reg_sel_t sel, input logic [31:0] val);
        send_item(REQ_SETUP, ch, sel, val, 8'd0);
    endtask

    task automatic trigger(input logic [1:0] ch);
        send_item(REQ_TRIGGER, ch, SEL_SOURCE, 32'd0, 8'd0);
    endtask

    task automatic return_byte(input logic [7:0] rb);
        send_item(REQ_READ_BYTE, 2'd0, SEL_SOURCE, 32'd0, rb);
    endtask

    // Address-like values with extra weight on the wrap points.
    function automatic logic [31:0] pick_word();
        logic [31:0] w;
        case ($urandom_range(0, 5))
            0:       w = 32'd0;
            1:       w = 32'hFFFF_FFFF;
            2:       w = 32'hFFFF_FFFF - $urandom_range(0, 7);
            default: w = $urandom;
        endcase
        return w;
    endfunction

    // Load one random channel register, keeping counts mostly small.
    task automatic random_setup();
        logic [1:0]  ch;
        reg_sel_t    sel;
        logic [31:0] val;
        ch  = 2'($urandom_range(0, NUM_CH - 1));
        sel = reg_sel_t'($urandom_range(0, 3));
        val = pick_word();
        if (sel == SEL_COUNT && $urandom_range(0, 3) != 0)
            val = ($urandom & 32'hFFFF_0000) | $urandom_range(0, 3);
        setup_reg(ch, sel, val);
    endtask

    // Directed: address and count wrap, plus items that must be ignored.
    task automatic test_wrap_and_ignored();
        setup_reg(2'd0, SEL_SOURCE, 32'hFFFF_FFFE);
        setup_reg(2'd0, SEL_TARGET, 32'd1);
        setup_reg(2'd0, SEL_COUNT, 32'd0);
        setup_reg(2'd0, SEL_MODE_SIZE, mode_word(MODE_DEC_TGT, SIZE_WORD_ALT));
        return_byte(8'h77);
        send_item(REQ_UNUSED, 2'd3, SEL_MODE_SIZE, 32'hFFFF_FFFF, 8'hFF);
        trigger(2'd0);
        trigger(2'd1);
        return_byte(8'h00);
        return_byte(8'hFF);
        return_byte(8'h5A);
        return_byte(8'hA5);
    endtask

    // Directed: modes that only report status.
    task automatic test_status_only_modes();
        setup_reg(2'd1, SEL_MODE_SIZE, mode_word(MODE_SRC_ONLY, SIZE_WORD));
        trigger(2'd1);
        setup_reg(2'd2, SEL_MODE_SIZE, mode_word(MODE_NOP_HI, SIZE_BYTE));
        trigger(2'd2);
        setup_reg(2'd0, SEL_MODE_SIZE, mode_word(MODE_NOP_LO, SIZE_HALF));
        trigger(2'd0);
    endtask

    // Directed: the unit shrinks while its reads are outstanding.
    task automatic test_setup_while_reading();
        setup_reg(2'd3, SEL_COUNT, 32'hFFFF_0001);
        setup_reg(2'd3, SEL_MODE_SIZE, mode_word(MODE_INC_SRC, SIZE_HALF) | 32'hFFFF_FFE0);
        trigger(2'd3);
        setup_reg(2'd3, SEL_MODE_SIZE, mode_word(MODE_DEC_SRC, SIZE_BYTE));
        return_byte(8'h3C);
    endtask

    // Directed: hold mode with a two-byte unit.
    task automatic test_hold_mode();
        setup_reg(2'd2, SEL_MODE_SIZE, mode_word(MODE_HOLD, SIZE_HALF));
        trigger(2'd2);
        return_byte(8'h81);
        return_byte(8'h7E);
    endtask

    // Random traffic: mostly complete units, some setups mid-read, some noise.
    task automatic test_random_traffic(input int n_items, input bit allow_idle);
        int goal;
        int pick;
        goal = items_sent + n_items;
        while (items_sent < goal)
        begin
            if (allow_idle && $urandom_range(0, 19) == 0)
                idling_on = !idling_on;
            pick = $urandom_range(0, 9);
            if (pick < 4)
                random_setup();
            else if (pick < 8)
            begin
                trigger(2'($urandom_range(0, NUM_CH - 1)));
                while (reads_awaited)
                begin
                    if ($urandom_range(0, 7) == 0)
                        random_setup();
                    else if ($urandom_range(0, 9) == 0)
                        trigger(2'($urandom_range(0, NUM_CH - 1)));
                    else
                        return_byte(8'($urandom_range(0, 255)));
                end
            end
            else
                send_item(req_kind_t'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                          reg_sel_t'($urandom_range(0, 3)), pick_word(),
                          8'($urandom_range(0, 255)));
        end
    endtask

    // Long receiver hold-off while triggers keep coming, so the input stalls.
    task automatic test_output_backpressure();
        idling_on = 1'b0;
        setup_reg(2'd1, SEL_MODE_SIZE, mode_word(MODE_SRC_ONLY, SIZE_HALF));
        setup_reg(2'd0, SEL_MODE_SIZE, mode_word(MODE_INC_TGT, SIZE_WORD));
        hold_req = 1'b1;
        for (int i = 0; i < 24; i++)
        begin
            trigger(2'd1);
            if (i % 6 == 0)
            begin
                trigger(2'd0);
                repeat (4) return_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                m_tready = 1'b1;
            end
            else if (idling_on && $urandom_range(0, 5) == 0)
            begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge clk);
                m_tready = 1'b1;
            end
            else
                m_tready = 1'b1;
        end
    end

    // Compare every bus item leaving the block with the oldest prediction.
    always @(posedge clk)
    begin : bus_op_check
        bus_op_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_bus_ops.size() == 0)
            begin
                $error("unexpected bus item: op_kind %0d address %h", m_tuser, m_tdata[31:0]);
                mismatch_count++;
            end
            else
            begin
                want = expected_bus_ops.pop_front();
                if (m_tuser !== want.kind)
                begin
                    $error("op_kind: expected %0d, got %0d", want.kind, m_tuser);
                    mismatch_count++;
                end
                if (m_tdata[31:0] !== want.addr)
                begin
                    $error("bus_address: expected %h, got %h", want.addr, m_tdata[31:0]);
                    mismatch_count++;
                end
                if (m_tdata[39:32] !== want.data)
                begin
                    $error("bus_data: expected %h, got %h", want.data, m_tdata[39:32]);
                    mismatch_count++;
                end
                if (m_tdata[41:40] !== want.ch)
                begin
                    $error("status_channel: expected %0d, got %0d", want.ch, m_tdata[41:40]);
                    mismatch_count++;
                end
                if (m_tdata[45:42] !== want.cost)
                begin
                    $error("cycle_cost: expected %0d, got %0d", want.cost, m_tdata[45:42]);
                    mismatch_count++;
                end
                if (m_tdata[46] !== want.done)
                begin
                    $error("transfer_done: expected %0d, got %0d", want.done, m_tdata[46]);
                    mismatch_count++;
                end
                if (m_tlast !== want.last)
                begin
                    $error("last_of_run: expected %0d, got %0d", want.last, m_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    // Main sequence.
    initial
    begin
        s_tvalid       = 1'b0;
        s_tdata        = 48'd0;
        s_tuser        = REQ_SETUP;
        rst_n          = 1'b0;
        idling_on      = 1'b0;
        hold_req       = 1'b0;
        mismatch_count = 0;
        items_sent     = 0;
        gather_word    = 32'd0;
        bytes_left     = 3'd0;
        read_channel   = 2'd0;
        reads_awaited  = 1'b0;
        for (int c = 0; c < NUM_CH; c++)
        begin
            src_addr[c]   = 32'd0;
            tgt_addr[c]   = 32'd0;
            xfer_count[c] = 16'd0;
            chan_mode[c]  = 5'd0;
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_wrap_and_ignored();
        test_status_only_modes();
        test_setup_while_reading();
        test_hold_mode();
        idling_on = 1'b1;
        test_random_traffic(50, 1'b1);
        test_output_backpressure();
        idling_on = 1'b0;
        test_random_traffic(20, 1'b0);

        @(negedge clk);
        s_tvalid = 1'b0;
        while (expected_bus_ops.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #4000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
design/dcts_pkg.sv
design/dcts_chan_mem.sv
design/dcts_engine.sv
design/dcts_emit.sv
design/dma_channel_transfer_step_core.sv
test/dma_channel_transfer_step_core_tb.sv
